/* sv/gn3_pkg.sv */
`default_nettype none
package gn3_pkg;

  // command codes
  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_PERM = 2'd1;
  localparam logic [1:0] CMD_GRAD = 2'd2;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 12;

  // saturation bounds of the result, Q1.14
  localparam int NOISE_MAX = 16384;

  // width of a corner value and of the blend values
  localparam int CV_W = 20;
  localparam int D_W  = 22;

  // register stages from input to output
  localparam int N_STAGES = 11;

  typedef struct packed {
    logic        perm_we;
    logic        grad_we;
    logic [7:0]  index;
    logic [7:0]  perm_value;
    logic [47:0] grad;      // {z, y, x}
  } tbl_wr_t;

endpackage
`default_nettype wire

/* sv/gn3_in_if.sv */
`default_nettype none
interface gn3_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         table_index;
  logic [7:0]         perm_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;
  logic signed [23:0] coord_z;

  modport source (output valid, cmd, table_index, perm_value, grad_x, grad_y, grad_z,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, cmd, table_index, perm_value, grad_x, grad_y, grad_z,
                coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

/* sv/gn3_out_if.sv */
`default_nettype none
interface gn3_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

/* sv/gradient_noise_3d.sv */
// gradient_noise_3d: 3D gradient noise in fixed point.
// Input channel in_ch carries one command word per handshake. A permutation
// write (cmd 1) or gradient write (cmd 2) stores one table entry and gives
// no result; it is taken only once the pipeline holds no evaluate word, so
// every evaluate sees the tables as of its own acceptance. An evaluate
// (cmd 0) carries a Q11.12 point; cmd 3 is dropped.
// Output channel out_ch returns one Q1.14 noise word per evaluate, in order.
// Throughput: one evaluate per cycle while out_ch takes results; the 11
// register stages (perm hash x, perm hash y, gradient read, dot products,
// corner round, then three lerp multiply/add pairs with the clamp in the
// last add) each take a new word every cycle unless stalled; the s-curve
// runs beside the three lookup stages. Each copy of the tables serves two
// read ports: 3 permutation copies and 4 gradient copies.
// A write following evaluates waits until the pipeline drains.
// Reset clears the valid bits only; table contents are undefined until
// written. When out_ch stalls, each stage holds its word and bubbles ahead
// of it close up, so input is accepted until every stage is full.
`default_nettype none
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  gn3_in_if.sink    in_ch,
  gn3_out_if.source out_ch
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int N  = N_STAGES;
  localparam int XW = 24 + IW;

  logic [N:1]   vld;
  logic [N+1:1] en;
  logic         accept;
  tbl_wr_t      wr;
  logic [IW-1:0]        lat_cell [3];
  logic [FRAC_BITS-1:0] frac [3];
  logic signed [23:0]   coord [3];
  logic [47:0]          grad [8];
  logic signed [CV_W-1:0] corner [8];
  logic [FRAC_BITS:0]   sw [3];

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[N+1] = out_ch.ready;
    for (int k = N; k >= 1; k--) en[k] = !vld[k] || en[k+1];
  end

  always_comb begin
    if (in_ch.cmd == CMD_PERM || in_ch.cmd == CMD_GRAD) in_ch.ready = (vld == '0);
    else                                                 in_ch.ready = en[1];
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= accept && in_ch.cmd == CMD_EVAL;
      for (int k = 2; k <= N; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign wr.perm_we    = accept && in_ch.cmd == CMD_PERM;
  assign wr.grad_we    = accept && in_ch.cmd == CMD_GRAD;
  assign wr.index      = in_ch.table_index;
  assign wr.perm_value = in_ch.perm_value;
  assign wr.grad       = {in_ch.grad_z, in_ch.grad_y, in_ch.grad_x};

  assign coord[0] = in_ch.coord_x;
  assign coord[1] = in_ch.coord_y;
  assign coord[2] = in_ch.coord_z;

  // lattice cell is floor(coord) folded to the table; fraction is the low bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [XW-1:0] ext;
      ext         = XW'(coord[a]);
      lat_cell[a] = ext[FRAC_BITS +: IW];
      frac[a]     = coord[a][FRAC_BITS-1:0];
    end
  end

  gn3_lookup #(.TABLE_SIZE(TABLE_SIZE)) u_lookup (
    .clk    (clk),
    .wr     (wr),
    .cell_x (lat_cell[0]),
    .cell_y (lat_cell[1]),
    .cell_z (lat_cell[2]),
    .en     (en[3:1]),
    .grad   (grad)
  );

  gn3_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
    .clk    (clk),
    .en     (en[5:1]),
    .frac   (frac),
    .grad   (grad),
    .corner (corner),
    .sw     (sw)
  );

  gn3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk         (clk),
    .en          (en[11:6]),
    .corner      (corner),
    .sw          (sw),
    .noise_value (out_ch.noise_value)
  );

  assign out_ch.valid = vld[N];

endmodule
`default_nettype wire

/* sv/gn3_lookup.sv */
`default_nettype none
module gn3_lookup import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  wire logic          clk,
  input  wire tbl_wr_t       wr,
  input  wire logic [IW-1:0] cell_x,
  input  wire logic [IW-1:0] cell_y,
  input  wire logic [IW-1:0] cell_z,
  input  wire logic [3:1]    en,
  output logic [47:0]        grad [8]
);

  logic [7:0]  perm_mem [3][TABLE_SIZE];
  logic [47:0] grad_mem [4][TABLE_SIZE];
  logic [IW-1:0] widx;

  logic [7:0]    i1, j1;
  logic [IW-1:0] y0_1, y1_1, z0_1;
  logic [7:0]    b00, b10, b01, b11;
  logic [IW-1:0] z0_2, z1_2;
  logic [IW-1:0] gaddr [8];

  function automatic logic [IW-1:0] fold(input logic [7:0] p, input logic [IW-1:0] c);
    logic [IW+8:0] s;
    s = (IW+9)'(p) + (IW+9)'(c);
    return s[IW-1:0];
  endfunction

  assign widx = IW'({24'd0, wr.index});

  // write every copy so that all read ports see one table
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (wr.perm_we) perm_mem[k][widx] <= wr.perm_value;
    end
    for (int k = 0; k < 4; k++) begin
      if (wr.grad_we) grad_mem[k][widx] <= wr.grad;
    end
  end

  // x hash
  always_ff @(posedge clk) begin
    if (en[1]) begin
      i1   <= perm_mem[0][cell_x];
      j1   <= perm_mem[0][cell_x + IW'(1)];
      y0_1 <= cell_y;
      y1_1 <= cell_y + IW'(1);
      z0_1 <= cell_z;
    end
  end

  // y hash
  always_ff @(posedge clk) begin
    if (en[2]) begin
      b00  <= perm_mem[1][fold(i1, y0_1)];
      b10  <= perm_mem[1][fold(j1, y0_1)];
      b01  <= perm_mem[2][fold(i1, y1_1)];
      b11  <= perm_mem[2][fold(j1, y1_1)];
      z0_2 <= z0_1;
      z1_2 <= z0_1 + IW'(1);
    end
  end

  // corner c = {z, y, x}
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      logic [7:0]    b;
      logic [IW-1:0] z;
      b = c[0] ? (c[1] ? b11 : b10) : (c[1] ? b01 : b00);
      z = c[2] ? z1_2 : z0_2;
      gaddr[c] = fold(b, z);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 8; c++) grad[c] <= grad_mem[c/2][gaddr[c]];
    end
  end

endmodule
`default_nettype wire

/* sv/gn3_corner.sv */
`default_nettype none
module gn3_corner import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic [5:1]           en,
  input  wire logic [FRAC_BITS-1:0] frac [3],
  input  wire logic [47:0]          grad [8],
  output logic signed [CV_W-1:0]    corner [8],
  output logic [FRAC_BITS:0]        sw [3]
);

  localparam int FB   = FRAC_BITS;
  localparam int PRW  = FB + 17;
  localparam int SUMW = FB + 20;
  localparam int TW   = FB + 2;

  logic [FB-1:0]   r1 [3], r2 [3], r3 [3];
  logic [2*FB-1:0] sq1 [3];
  logic [TW-1:0]   t1 [3];
  logic [3*FB+1:0] p2 [3];
  logic [FB:0]     s3 [3], s4 [3];
  logic signed [PRW-1:0] prod [8][3];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (en[1]) begin
        r1[a]  <= frac[a];
        sq1[a] <= (2*FB)'(frac[a]) * (2*FB)'(frac[a]);
        t1[a]  <= TW'(3 << FB) - {1'b0, frac[a], 1'b0};
      end
      if (en[2]) begin
        r2[a] <= r1[a];
        p2[a] <= (3*FB+2)'(sq1[a]) * (3*FB+2)'(t1[a]);
      end
      if (en[3]) begin
        r3[a] <= r2[a];
        s3[a] <= (FB+1)'((p2[a] + (3*FB+2)'(1 << (2*FB-1))) >> (2*FB));
      end
      if (en[4]) s4[a] <= s3[a];
      if (en[5]) sw[a] <= s4[a];
    end
  end

  // offset toward corner: r1 = r0 - one is {1, r0}
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < 3; a++) begin
          prod[c][a] <= $signed({c[a], r3[a]}) * $signed(grad[c][16*a +: 16]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 8; c++) begin
        logic signed [SUMW-1:0] sum;
        sum = SUMW'(prod[c][0]) + SUMW'(prod[c][1]) + SUMW'(prod[c][2])
            + SUMW'(1 << (FB-1));
        corner[c] <= CV_W'(sum >>> FB);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/gn3_blend.sv */
`default_nettype none
module gn3_blend import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic [11:6]           en,
  input  wire logic signed [CV_W-1:0] corner [8],
  input  wire logic [FRAC_BITS:0]    sw [3],
  output logic signed [15:0]         noise_value
);

  localparam int FB = FRAC_BITS;
  localparam int PW = D_W + FB + 3;

  logic signed [PW-1:0]  px [4], py [2], pz;
  logic signed [D_W-1:0] ax [4], av [4], ay [2], cv [2], az;
  logic [FB:0]           sy6, sy7, sz6, sz7, sz8, sz9;

  function automatic logic signed [PW-1:0] wprod(input logic [FB:0] s,
                                                 input logic signed [D_W-1:0] a,
                                                 input logic signed [D_W-1:0] b);
    logic signed [D_W:0]  d;
    logic signed [PW-1:0] p;
    d = (D_W+1)'(b) - (D_W+1)'(a);
    p = $signed({1'b0, s}) * d;
    return p;
  endfunction

  function automatic logic signed [D_W-1:0] wadd(input logic signed [D_W-1:0] a,
                                                 input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + PW'(1 << (FB-1))) >>> FB;
    return a + D_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        ax[k] <= D_W'(corner[2*k]);
        px[k] <= wprod(sw[0], D_W'(corner[2*k]), D_W'(corner[2*k+1]));
      end
      sy6 <= sw[1];
      sz6 <= sw[2];
    end
    if (en[7]) begin
      for (int k = 0; k < 4; k++) av[k] <= wadd(ax[k], px[k]);
      sy7 <= sy6;
      sz7 <= sz6;
    end
    if (en[8]) begin
      for (int k = 0; k < 2; k++) begin
        ay[k] <= av[2*k];
        py[k] <= wprod(sy7, av[2*k], av[2*k+1]);
      end
      sz8 <= sz7;
    end
    if (en[9]) begin
      for (int k = 0; k < 2; k++) cv[k] <= wadd(ay[k], py[k]);
      sz9 <= sz8;
    end
    if (en[10]) begin
      az <= cv[0];
      pz <= wprod(sz9, cv[0], cv[1]);
    end
    if (en[11]) begin
      logic signed [D_W-1:0] res;
      res = wadd(az, pz);
      if (res > D_W'(NOISE_MAX))       noise_value <= 16'(NOISE_MAX);
      else if (res < -D_W'(NOISE_MAX)) noise_value <= -16'(NOISE_MAX);
      else                             noise_value <= 16'(res);
    end
  end

endmodule
`default_nettype wire
